### hw/rtl/i2c_master_bit_engine_assert.svh
// Assertion macros shared by the I2C master bit engine modules.
`ifndef I2C_MASTER_BIT_ENGINE_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_ASSERT_SVH
`ifndef SYNTH
// Property checked at every clock edge outside reset.
`define I2C_MBE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Antecedent in one cycle implies consequent in the next.
`define I2C_MBE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define I2C_MBE_ASSERT(lbl, prop, msg)
`define I2C_MBE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### hw/rtl/i2c_mbe_pkg.sv
// Shared types and constants for the I2C master bit engine.
`timescale 1ns / 1ps
`default_nettype none
package i2c_mbe_pkg;

  localparam int CMD_W = 3;

  localparam logic [CMD_W-1:0] CMD_NONE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_START = 3'd1;
  localparam logic [CMD_W-1:0] CMD_STOP  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_WRITE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_WACK  = 3'd5;

  localparam int PHASE_W = 5;

  // Phase markers of the longest sequence (read).
  localparam logic [PHASE_W-1:0] PH_FIRST    = 5'd0;
  localparam logic [PHASE_W-1:0] PH_SECOND   = 5'd1;
  localparam logic [PHASE_W-1:0] PH_ACK_LOW  = 5'd16;
  localparam logic [PHASE_W-1:0] PH_ACK_HIGH = 5'd17;
  localparam logic [PHASE_W-1:0] PH_LAST     = 5'd18;

  localparam logic [7:0] TIMEOUT_RESET = 8'd250;

  // Register map: one register, index taken from paddr[2].
  localparam logic REG_ACK_TIMEOUT = 1'b0;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [7:0]       tx;
    logic             send_ack;
    logic             sda;
  } item_t;

endpackage
`default_nettype wire

### hw/rtl/i2c_master_bit_engine.sv
// Top level of the I2C master bit engine: front end, queue, sequencer, APB register.
// A tick's result is valid once it has passed the staging register, the queue and
// the sequencer state register. One tick per cycle unless out_ready stalls output;
// the sequencer advances one bus phase per tick.
// Reset (rst, synchronous): queue empty, SCL/SDA high and driven, ack_timeout = 250.
`timescale 1ns / 1ps
`default_nettype none
module i2c_master_bit_engine
  import i2c_mbe_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  action,
  input  wire logic [7:0]  tx_byte,
  input  wire logic        send_ack,
  input  wire logic        sda_sample,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             scl_level,
  output logic             sda_level,
  output logic             sda_enable,
  output logic             busy_res,
  output logic             done_res,
  output logic [7:0]       rx_byte,
  output logic             ack_failed,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_not_empty;
  item_t      push_item;
  item_t      head;
  logic [7:0] ack_timeout;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_timeout <= TIMEOUT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_ACK_TIMEOUT) begin
      ack_timeout <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == REG_ACK_TIMEOUT) ? {24'd0, ack_timeout} : 32'd0;

  i2c_mbe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .tx_byte    (tx_byte),
    .send_ack   (send_ack),
    .sda_sample (sda_sample),
    .q_full     (q_full),
    .push       (push),
    .push_item  (push_item)
  );

  i2c_mbe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head      (head)
  );

  i2c_mbe_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .head        (head),
    .pop         (pop),
    .ack_timeout (ack_timeout),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .scl_level   (scl_level),
    .sda_level   (sda_level),
    .sda_enable  (sda_enable),
    .busy_res    (busy_res),
    .done_res    (done_res),
    .rx_byte     (rx_byte),
    .ack_failed  (ack_failed)
  );

endmodule
`default_nettype wire

### hw/rtl/i2c_mbe_front.sv
// Front end: accepts ticks, decodes the action and stages them for the queue.
`timescale 1ns / 1ps
`default_nettype none
module i2c_mbe_front
  import i2c_mbe_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [2:0]   action,
  input  wire logic [7:0]   tx_byte,
  input  wire logic         send_ack,
  input  wire logic         sda_sample,
  input  wire logic         q_full,
  output logic              push,
  output item_t             push_item
);

  logic             stg_valid;
  item_t            stg_item;
  logic [CMD_W-1:0] cmd_dec;

  // Unknown action codes become no-ops.
  always_comb begin
    unique case (action)
      CMD_START: cmd_dec = CMD_START;
      CMD_STOP:  cmd_dec = CMD_STOP;
      CMD_WRITE: cmd_dec = CMD_WRITE;
      CMD_READ:  cmd_dec = CMD_READ;
      CMD_WACK:  cmd_dec = CMD_WACK;
      default:   cmd_dec = CMD_NONE;
    endcase
  end

  assign push      = stg_valid && !q_full;
  assign in_ready  = !stg_valid || !q_full;
  assign push_item = stg_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      stg_valid <= 1'b1;
    end else if (push) begin
      stg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_item.cmd      <= cmd_dec;
      stg_item.tx       <= tx_byte;
      stg_item.send_ack <= send_ack;
      stg_item.sda      <= sda_sample;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/i2c_mbe_queue.sv
// Short FIFO between the front end and the bus sequencer.
`timescale 1ns / 1ps
`default_nettype none
module i2c_mbe_queue
  import i2c_mbe_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t push_item,
  output logic       full,
  input  wire logic  pop,
  output logic       not_empty,
  output item_t      head
);

  item_t             mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = count == QCNT_W'(QDEPTH);
  assign not_empty = count != '0;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  `include "i2c_master_bit_engine_assert.svh"

  `I2C_MBE_ASSERT(a_q_no_overflow, !(push && full), "queue push while full")
  `I2C_MBE_ASSERT(a_q_no_underflow, !(pop && !not_empty), "queue pop while empty")

endmodule
`default_nettype wire

### hw/rtl/i2c_mbe_seq.sv
// Back end: bus phase sequencer; its state registers are the result register.
`timescale 1ns / 1ps
`default_nettype none
module i2c_mbe_seq
  import i2c_mbe_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_not_empty,
  input  wire item_t       head,
  output logic             pop,
  input  wire logic [7:0]  ack_timeout,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             scl_level,
  output logic             sda_level,
  output logic             sda_enable,
  output logic             busy_res,
  output logic             done_res,
  output logic [7:0]       rx_byte,
  output logic             ack_failed
);

  logic [CMD_W-1:0]   cmd, cmd_next;
  logic [PHASE_W-1:0] phase, phase_next;
  logic [7:0]         shift_reg, shift_reg_next;
  logic [7:0]         wait_count, wait_count_next;
  logic               ack_choice, ack_choice_next;
  logic               scl_reg, scl_reg_next;
  logic               sda_reg, sda_reg_next;
  logic               sda_oe_reg, sda_oe_reg_next;
  logic [7:0]         rx_hold, rx_hold_next;
  logic               fail_flag, fail_flag_next;
  logic               done_next;
  logic               advance;

  // Take the next tick when the result slot is free or being emptied.
  assign pop = q_not_empty && (!out_valid || out_ready);

  always_comb begin
    cmd_next        = cmd;
    phase_next      = phase;
    shift_reg_next  = shift_reg;
    wait_count_next = wait_count;
    ack_choice_next = ack_choice;
    scl_reg_next    = scl_reg;
    sda_reg_next    = sda_reg;
    sda_oe_reg_next = sda_oe_reg;
    rx_hold_next    = rx_hold;
    fail_flag_next  = fail_flag;
    done_next       = 1'b0;
    advance         = 1'b0;

    // Latch a new command only while idle.
    if (cmd == CMD_NONE && head.cmd != CMD_NONE) begin
      cmd_next        = head.cmd;
      phase_next      = PH_FIRST;
      wait_count_next = '0;
      fail_flag_next  = 1'b0;
      shift_reg_next  = (head.cmd == CMD_WRITE) ? head.tx : 8'd0;
      if (head.cmd == CMD_READ) begin
        ack_choice_next = head.send_ack;
      end
    end

    unique case (cmd_next)
      CMD_START: begin
        if (phase_next == PH_FIRST) begin
          sda_oe_reg_next = 1'b1;
          sda_reg_next    = 1'b1;
          scl_reg_next    = 1'b1;
          advance         = 1'b1;
        end else if (phase_next == PH_SECOND) begin
          sda_reg_next = 1'b0;
          advance      = 1'b1;
        end else begin
          scl_reg_next = 1'b0;
          done_next    = 1'b1;
        end
      end
      CMD_STOP: begin
        if (phase_next == PH_FIRST) begin
          sda_oe_reg_next = 1'b1;
          scl_reg_next    = 1'b0;
          sda_reg_next    = 1'b0;
          advance         = 1'b1;
        end else if (phase_next == PH_SECOND) begin
          scl_reg_next = 1'b1;
          advance      = 1'b1;
        end else begin
          sda_reg_next = 1'b1;
          done_next    = 1'b1;
        end
      end
      CMD_WRITE: begin
        if (phase_next < PH_ACK_LOW) begin
          if (!phase_next[0]) begin
            scl_reg_next    = 1'b0;
            sda_oe_reg_next = 1'b1;
            sda_reg_next    = shift_reg_next[7];
            shift_reg_next  = {shift_reg_next[6:0], 1'b0};
          end else begin
            scl_reg_next = 1'b1;
          end
          advance = 1'b1;
        end else begin
          scl_reg_next = 1'b0;
          done_next    = 1'b1;
        end
      end
      CMD_READ: begin
        if (phase_next < PH_ACK_LOW) begin
          if (!phase_next[0]) begin
            scl_reg_next    = 1'b0;
            sda_oe_reg_next = 1'b0;
          end else begin
            scl_reg_next   = 1'b1;
            shift_reg_next = {shift_reg_next[6:0], head.sda};
          end
          advance = 1'b1;
        end else if (phase_next == PH_ACK_LOW) begin
          scl_reg_next    = 1'b0;
          sda_oe_reg_next = 1'b1;
          sda_reg_next    = !ack_choice_next;
          rx_hold_next    = shift_reg_next;
          advance         = 1'b1;
        end else if (phase_next == PH_ACK_HIGH) begin
          scl_reg_next = 1'b1;
          advance      = 1'b1;
        end else begin
          scl_reg_next = 1'b0;
          done_next    = 1'b1;
        end
      end
      CMD_WACK: begin
        if (phase_next == PH_FIRST) begin
          sda_oe_reg_next = 1'b0;
          sda_reg_next    = 1'b1;
          advance         = 1'b1;
        end else if (phase_next == PH_SECOND) begin
          scl_reg_next = 1'b1;
          advance      = 1'b1;
        end else if (!head.sda) begin
          scl_reg_next = 1'b0;
          done_next    = 1'b1;
        end else if (wait_count_next >= ack_timeout) begin
          // Timed out: flag failure and run the first stop phase now.
          fail_flag_next  = 1'b1;
          cmd_next        = CMD_STOP;
          sda_oe_reg_next = 1'b1;
          scl_reg_next    = 1'b0;
          sda_reg_next    = 1'b0;
          phase_next      = PH_SECOND;
        end else begin
          wait_count_next = wait_count_next + 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (advance) begin
      phase_next = phase_next + 1'b1;
    end
    if (done_next) begin
      cmd_next   = CMD_NONE;
      phase_next = PH_FIRST;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      cmd        <= CMD_NONE;
      phase      <= PH_FIRST;
      shift_reg  <= '0;
      wait_count <= '0;
      ack_choice <= 1'b0;
      scl_reg    <= 1'b1;
      sda_reg    <= 1'b1;
      sda_oe_reg <= 1'b1;
      rx_hold    <= '0;
      fail_flag  <= 1'b0;
      done_res   <= 1'b0;
    end else begin
      if (pop) begin
        out_valid  <= 1'b1;
        cmd        <= cmd_next;
        phase      <= phase_next;
        shift_reg  <= shift_reg_next;
        wait_count <= wait_count_next;
        ack_choice <= ack_choice_next;
        scl_reg    <= scl_reg_next;
        sda_reg    <= sda_reg_next;
        sda_oe_reg <= sda_oe_reg_next;
        rx_hold    <= rx_hold_next;
        fail_flag  <= fail_flag_next;
        done_res   <= done_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign scl_level  = scl_reg;
  assign sda_level  = sda_reg;
  assign sda_enable = sda_oe_reg;
  assign busy_res   = cmd != CMD_NONE;
  assign rx_byte    = rx_hold;
  assign ack_failed = fail_flag;

  `include "i2c_master_bit_engine_assert.svh"

  `I2C_MBE_ASSERT(a_done_idle, !(done_res && busy_res), "done reported while still busy")
  `I2C_MBE_ASSERT(a_phase_range, (cmd == CMD_NONE) ? (phase == PH_FIRST) : (phase <= PH_LAST), "phase out of range")
  `I2C_MBE_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, $stable(phase) && $stable(cmd), "state moved during output stall")

endmodule
`default_nettype wire
